// File: src/message_header_parser_unit_defines.svh
// assertion macros shared by the rtl
`ifndef MESSAGE_HEADER_PARSER_UNIT_DEFINES_SVH
`define MESSAGE_HEADER_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define MHP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("mhp assertion failed");
`define MHP_ASSERT_NEVER(lbl, expr) \
    `MHP_ASSERT(lbl, !(expr))
`else
`define MHP_ASSERT(lbl, prop)
`define MHP_ASSERT_NEVER(lbl, expr)
`endif

`endif

// File: src/mhp_pkg.sv
package mhp_pkg;

    typedef enum logic [6:0] {
        PH_FLAG  = 7'b0000001,
        PH_ID    = 7'b0000010,
        PH_CODE1 = 7'b0000100,
        PH_CODE2 = 7'b0001000,
        PH_RLEN  = 7'b0010000,
        PH_RCHAR = 7'b0100000,
        PH_BODY  = 7'b1000000
    } t_phase;

    typedef enum logic [2:0] {
        CLS_FLAG       = 3'd0,
        CLS_ID         = 3'd1,
        CLS_ROUTE_CODE = 3'd2,
        CLS_ROUTE_LEN  = 3'd3,
        CLS_ROUTE_CHAR = 3'd4,
        CLS_BODY       = 3'd5
    } t_byte_class;

    localparam logic [2:0] KIND_REQUEST  = 3'd0;
    localparam logic [2:0] KIND_NOTIFY   = 3'd1;
    localparam logic [2:0] KIND_RESPONSE = 3'd2;
    localparam logic [2:0] KIND_PUSH     = 3'd3;

    localparam logic [2:0] ID_GROUP_MAX  = 3'd7;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_TRUNCATED = 1'b1;

    typedef struct packed {
        logic       end_of_message;
        logic [7:0] data_byte;
    } t_in_item;

    // first field in the highest bits
    typedef struct packed {
        logic        parse_status;
        logic        id_complete;
        logic [31:0] message_id;
        logic        gzip_flag;
        logic        route_compressed;
        logic [2:0]  message_kind;
        logic [7:0]  byte_value;
        t_byte_class byte_class;
    } t_result;

    localparam int RESULT_W   = $bits(t_result);
    localparam int M_TDATA_W  = ((RESULT_W + 7) / 8) * 8;

endpackage

// File: src/mhp_in_stage.sv
module mhp_in_stage import mhp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    input  logic     i_pop,
    output logic     o_ready,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_pop;
    assign n_valid = (o_ready) ? i_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: src/mhp_parse_core.sv
module mhp_parse_core import mhp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_advance,
    input  t_in_item i_item,
    output t_result  o_result
);

    t_phase      r_phase;
    logic [2:0]  r_kind;
    logic        r_route_comp;
    logic        r_gzip;
    logic [31:0] r_id_accum;
    logic [2:0]  r_id_group;
    logic [7:0]  r_route_rem;

    t_phase      n_phase;
    logic [2:0]  n_kind;
    logic        n_route_comp;
    logic        n_gzip;
    logic [31:0] n_id_accum;
    logic [2:0]  n_id_group;
    logic [7:0]  n_route_rem;

    t_phase      w_next;
    t_byte_class w_cls;
    logic        w_done_id;
    logic [31:0] w_digit_shifted;
    logic [7:0]  w_byte;

    assign w_byte = i_item.data_byte;

    // id digit placed at 7 * group, dropped above bit 31
    always_comb begin
        case (r_id_group)
            3'd0:    w_digit_shifted = {25'b0, w_byte[6:0]};
            3'd1:    w_digit_shifted = {18'b0, w_byte[6:0], 7'b0};
            3'd2:    w_digit_shifted = {11'b0, w_byte[6:0], 14'b0};
            3'd3:    w_digit_shifted = {4'b0, w_byte[6:0], 21'b0};
            3'd4:    w_digit_shifted = {w_byte[3:0], 28'b0};
            default: w_digit_shifted = 32'b0;
        endcase
    end

    always_comb begin
        n_kind       = r_kind;
        n_route_comp = r_route_comp;
        n_gzip       = r_gzip;
        n_id_accum   = r_id_accum;
        n_id_group   = r_id_group;
        n_route_rem  = r_route_rem;
        w_cls        = CLS_BODY;
        w_done_id    = 1'b0;
        w_next       = PH_BODY;
        case (r_phase)
            PH_ID: begin
                w_cls      = CLS_ID;
                n_id_accum = r_id_accum | w_digit_shifted;
                if (r_id_group < ID_GROUP_MAX) begin
                    n_id_group = r_id_group + 3'd1;
                end
                if (!w_byte[7]) begin
                    w_done_id = 1'b1;
                    if (r_kind == KIND_REQUEST) begin
                        w_next = r_route_comp ? PH_CODE1 : PH_RLEN;
                    end else begin
                        w_next = PH_BODY;
                    end
                end else begin
                    w_next = PH_ID;
                end
            end
            PH_CODE1: begin
                w_cls  = CLS_ROUTE_CODE;
                w_next = PH_CODE2;
            end
            PH_CODE2: begin
                w_cls  = CLS_ROUTE_CODE;
                w_next = PH_BODY;
            end
            PH_RLEN: begin
                w_cls       = CLS_ROUTE_LEN;
                n_route_rem = w_byte;
                w_next      = (w_byte == 8'd0) ? PH_BODY : PH_RCHAR;
            end
            PH_RCHAR: begin
                w_cls       = CLS_ROUTE_CHAR;
                n_route_rem = r_route_rem - 8'd1;
                w_next      = (n_route_rem == 8'd0) ? PH_BODY : PH_RCHAR;
            end
            PH_BODY: begin
                w_cls  = CLS_BODY;
                w_next = PH_BODY;
            end
            default: begin
                w_cls        = CLS_FLAG;
                n_route_comp = w_byte[0];
                n_kind       = w_byte[3:1];
                n_gzip       = w_byte[4];
                n_id_accum   = 32'b0;
                n_id_group   = 3'd0;
                n_route_rem  = 8'd0;
                if (n_kind == KIND_REQUEST || n_kind == KIND_RESPONSE) begin
                    w_next = PH_ID;
                end else if (n_kind == KIND_NOTIFY || n_kind == KIND_PUSH) begin
                    w_next = w_byte[0] ? PH_CODE1 : PH_RLEN;
                end else begin
                    w_next = PH_BODY;
                end
            end
        endcase
        n_phase = i_item.end_of_message ? PH_FLAG : w_next;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_FLAG;
            r_kind       <= 3'd0;
            r_route_comp <= 1'b0;
            r_gzip       <= 1'b0;
            r_id_accum   <= 32'b0;
            r_id_group   <= 3'd0;
            r_route_rem  <= 8'd0;
        end else if (i_advance) begin
            r_phase      <= n_phase;
            r_kind       <= n_kind;
            r_route_comp <= n_route_comp;
            r_gzip       <= n_gzip;
            r_id_accum   <= n_id_accum;
            r_id_group   <= n_id_group;
            r_route_rem  <= n_route_rem;
        end
    end

    always_comb begin
        o_result.byte_class       = w_cls;
        o_result.byte_value       = w_byte;
        o_result.message_kind     = n_kind;
        o_result.route_compressed = n_route_comp;
        o_result.gzip_flag        = n_gzip;
        o_result.message_id       = n_id_accum;
        o_result.id_complete      = w_done_id;
        o_result.parse_status     = (i_item.end_of_message && w_next != PH_BODY)
                                    ? STATUS_TRUNCATED : STATUS_OK;
    end

endmodule

// File: src/mhp_out_stage.sv
module mhp_out_stage import mhp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_result,
    input  logic    i_last,
    input  logic    i_ready,
    output logic    o_load_ok,
    output logic    o_valid,
    output t_result o_result,
    output logic    o_last
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;
    logic    r_last;

    assign o_load_ok = !r_valid || i_ready;
    assign n_valid   = o_load_ok ? i_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load_ok && i_valid) begin
            r_result <= i_result;
            r_last   <= i_last;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
    assign o_last   = r_last;

endmodule

// File: src/message_header_parser_unit.sv
// message header parser, one message byte per transaction, one result per byte
// an input byte is registered in the input stage, its result in the output stage
// throughput: 1 byte per cycle unless the output stalls, set by the phase update
// reset: synchronous active-low i_rst_n clears the pipeline and returns to flag byte
// a result waiting on the output does not block the input register from filling
`include "message_header_parser_unit_defines.svh"

module message_header_parser_unit import mhp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [7:0]           i_s_axis_tdata,  // data_byte
    input  logic                 i_s_axis_tlast,  // end_of_message
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // byte_class, byte_value, message_kind, route_compressed, gzip_flag,
    // message_id, id_complete, parse_status, zero pad
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    output logic                 o_m_axis_tlast   // last_out
);

    t_in_item w_s_item;
    t_in_item w_in_item;
    logic     w_in_valid;
    logic     w_load_ok;
    logic     w_pop;
    t_result  w_core_result;
    t_result  w_out_result;

    assign w_s_item.data_byte      = i_s_axis_tdata;
    assign w_s_item.end_of_message = i_s_axis_tlast;
    assign w_pop                   = w_in_valid && w_load_ok;

    mhp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_item  (w_s_item),
        .i_pop   (w_pop),
        .o_ready (o_s_axis_tready),
        .o_valid (w_in_valid),
        .o_item  (w_in_item)
    );

    mhp_parse_core u_parse_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_pop),
        .i_item    (w_in_item),
        .o_result  (w_core_result)
    );

    mhp_out_stage u_out_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_in_valid),
        .i_result  (w_core_result),
        .i_last    (w_in_item.end_of_message),
        .i_ready   (i_m_axis_tready),
        .o_load_ok (w_load_ok),
        .o_valid   (o_m_axis_tvalid),
        .o_result  (w_out_result),
        .o_last    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {{(M_TDATA_W - RESULT_W){1'b0}}, w_out_result};

    `MHP_ASSERT(a_pop_fills_out, w_pop |=> o_m_axis_tvalid)
    `MHP_ASSERT(a_in_held_until_pop, (w_in_valid && !w_pop) |=> w_in_valid)
    `MHP_ASSERT_NEVER(a_status_needs_last,
        o_m_axis_tvalid && w_out_result.parse_status && !o_m_axis_tlast)
    `MHP_ASSERT_NEVER(a_id_done_on_id_byte,
        o_m_axis_tvalid && w_out_result.id_complete && w_out_result.byte_class != CLS_ID)

endmodule
